// ===== hdl/stbs_pkg.sv =====
// stbs_pkg: shared types, sizes and codes for the sorted table bound search
// used by stbs_table, stbs_cell, sorted_table_bound_search and stbs_checker
// no dependencies
package stbs_pkg;

	localparam int DEPTH      = 1024;
	localparam int VALUE_BITS = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	// worst-case probe count for a table of DEPTH entries
	localparam int N_STEPS    = CNT_W;
	localparam int POS_W      = 10;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [POS_W-1:0]             pos_t;
	typedef logic [1:0]                   mode_t;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam mode_t MODE_LAST_BELOW        = 2'd0;
	localparam mode_t MODE_FIRST_AT_OR_ABOVE = 2'd1;
	localparam mode_t MODE_LAST_AT_OR_BELOW  = 2'd2;
	localparam mode_t MODE_FIRST_ABOVE       = 2'd3;

	// search window handed from cell to cell
	typedef struct packed {
		logic   valid;
		cnt_t   lo;
		cnt_t   hi;
		logic   right;  // probe data sits on read port b
		value_t key;
		mode_t  mode;
	} step_t;

	typedef struct packed {
		logic found;
		pos_t position;
		logic overflowed;
	} res_t;

	function automatic cnt_t mid_of(cnt_t a, cnt_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W:1];
	endfunction

endpackage

// ===== hdl/stbs_table.sv =====
// stbs_table: value storage, one write port and two registered read ports
// depends on stbs_pkg
module stbs_table (
	input  logic           clk,
	input  logic           we,
	input  stbs_pkg::addr_t  waddr,
	input  stbs_pkg::value_t wdata,
	input  stbs_pkg::addr_t  raddr_a,
	input  stbs_pkg::addr_t  raddr_b,
	output stbs_pkg::value_t rdata_a,
	output stbs_pkg::value_t rdata_b
);
	import stbs_pkg::*;

	value_t mem_q [DEPTH];
	value_t rd_a_q;
	value_t rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== hdl/stbs_cell.sv =====
// stbs_cell: one probe of the bound search, holds a search window in a register
// and hands the narrowed window to the next cell; depends on stbs_pkg
module stbs_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  stbs_pkg::step_t  step_i,
	input  stbs_pkg::value_t rd_a,
	input  stbs_pkg::value_t rd_b,
	output stbs_pkg::step_t  step_o,
	output logic             active,
	output stbs_pkg::addr_t  addr_a,
	output stbs_pkg::addr_t  addr_b
);
	import stbs_pkg::*;

	step_t  st_q;
	value_t probe;
	cnt_t   mid;
	cnt_t   mid_p1;
	cnt_t   mid_l;
	cnt_t   mid_r;
	logic   run;
	logic   incl;
	logic   hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= step_i;
		end
	end

	always_comb begin
		probe  = st_q.right ? rd_b : rd_a;
		incl   = (st_q.mode == MODE_LAST_AT_OR_BELOW) || (st_q.mode == MODE_FIRST_ABOVE);
		mid    = mid_of(st_q.lo, st_q.hi);
		mid_p1 = mid + 1'b1;
		run    = st_q.lo < st_q.hi;
		hit    = incl ? (probe <= st_q.key) : (probe < st_q.key);

		step_o       = st_q;
		step_o.right = 1'b0;
		if (run) begin
			if (hit) begin
				step_o.lo    = mid_p1;
				step_o.right = 1'b1;
			end else begin
				step_o.hi = mid;
			end
		end

		// fetch both possible next probes, the next cell picks one
		mid_l  = mid_of(st_q.lo, mid);
		mid_r  = mid_of(mid_p1, st_q.hi);
		addr_a = mid_l[ADDR_W-1:0];
		addr_b = mid_r[ADDR_W-1:0];
	end

	assign active = st_q.valid;

endmodule

// ===== hdl/sorted_table_bound_search.sv =====
// sorted_table_bound_search: ascending table with lower/upper bound queries
// depends on stbs_pkg, stbs_table, stbs_cell
//
//  channel   direction  handshake             fields
//  request   in         req_valid / req_stall op, restart, mode, value
//  response  out        rsp_valid / rsp_stall found, position, overflowed
//
// an append does not enter the chain; a query walks a chain of N_STEPS probe cells
// (11 for 1024 entries), and its result is registered to drive rsp_valid,
// so a new request is taken only after the query has left the chain
// every probe cell reads the table through one of two speculative read ports
// requests stall while a query is in the chain or a second response is held
// reset empties the table and clears the overflow flag; no clearing pass
module sorted_table_bound_search (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic             op,
	input  logic             restart,
	input  stbs_pkg::mode_t  mode,
	input  stbs_pkg::value_t value,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic             found,
	output stbs_pkg::pos_t   position,
	output logic             overflowed
);
	import stbs_pkg::*;

	step_t  link [N_STEPS+1];
	logic   active_c [N_STEPS];
	addr_t  addr_a_c [N_STEPS];
	addr_t  addr_b_c [N_STEPS];

	cnt_t   count_q;
	logic   ovf_q;
	logic   busy;
	logic   req_take;

	cnt_t   eff_count;
	cnt_t   first_mid;
	logic   we;
	addr_t  raddr_a;
	addr_t  raddr_b;
	value_t rdata_a;
	value_t rdata_b;

	res_t   res;
	cnt_t   bnd;
	cnt_t   pos_c;
	logic   last_kind;
	res_t   out_q;
	logic   out_v_q;
	res_t   hold_q;
	logic   hold_v_q;
	logic   out_free;

	assign req_take  = req_valid && !req_stall;
	assign req_stall = busy || hold_v_q;

	always_comb begin
		busy = 1'b0;
		for (int k = 0; k < N_STEPS; k++) begin
			busy = busy || active_c[k];
		end
	end

	// table fill
	assign eff_count = restart ? '0 : count_q;
	assign we        = req_take && (op == OP_APPEND) && (eff_count < cnt_t'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (req_take && (op == OP_APPEND)) begin
			if (eff_count < cnt_t'(DEPTH)) begin
				count_q <= eff_count + 1'b1;
				ovf_q   <= restart ? 1'b0 : ovf_q;
			end else begin
				count_q <= eff_count;
				ovf_q   <= 1'b1;
			end
		end
	end

	// read address: first probe on acceptance, otherwise the active cell
	always_comb begin
		first_mid = mid_of('0, count_q);
		raddr_a   = first_mid[ADDR_W-1:0];
		raddr_b   = '0;
		for (int k = 0; k < N_STEPS; k++) begin
			if (active_c[k]) begin
				raddr_a = addr_a_c[k];
				raddr_b = addr_b_c[k];
			end
		end
	end

	stbs_table u_table (
		.clk     (clk),
		.we      (we),
		.waddr   (eff_count[ADDR_W-1:0]),
		.wdata   (value),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_comb begin
		link[0].valid = req_take && (op == OP_QUERY);
		link[0].lo    = '0;
		link[0].hi    = count_q;
		link[0].right = 1'b0;
		link[0].key   = value;
		link[0].mode  = mode;
	end

	for (genvar k = 0; k < N_STEPS; k++) begin : g_cell
		stbs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step_i (link[k]),
			.rd_a   (rdata_a),
			.rd_b   (rdata_b),
			.step_o (link[k+1]),
			.active (active_c[k]),
			.addr_a (addr_a_c[k]),
			.addr_b (addr_b_c[k])
		);
	end

	// bound count to found flag and index
	always_comb begin
		bnd       = link[N_STEPS].lo;
		last_kind = (link[N_STEPS].mode == MODE_LAST_BELOW) ||
			(link[N_STEPS].mode == MODE_LAST_AT_OR_BELOW);
		if (last_kind) begin
			res.found = bnd != '0;
			pos_c     = bnd - 1'b1;
		end else begin
			res.found = bnd < count_q;
			pos_c     = bnd;
		end
		if (!res.found) begin
			pos_c = '0;
		end
		res.position   = POS_W'(pos_c);
		res.overflowed = ovf_q;
	end

	assign out_free = !out_v_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (hold_v_q) begin
					out_v_q  <= 1'b1;
					hold_v_q <= 1'b0;
				end else begin
					out_v_q <= link[N_STEPS].valid;
				end
			end else if (link[N_STEPS].valid) begin
				hold_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= hold_v_q ? hold_q : res;
		end else if (link[N_STEPS].valid) begin
			hold_q <= res;
		end
	end

	assign rsp_valid  = out_v_q;
	assign found      = out_q.found;
	assign position   = out_q.position;
	assign overflowed = out_q.overflowed;

endmodule

// ===== hdl/stbs_checker.sv =====
// stbs_port_checks: port-level checks for sorted_table_bound_search, bound to it
// depends on stbs_pkg
module stbs_port_checks (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             op,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input logic             found,
	input stbs_pkg::pos_t   position,
	input logic             overflowed
);
	import stbs_pkg::*;

	logic query_take;
	assign query_take = req_valid && !req_stall && (op == OP_QUERY);

	// a stalled response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(found) && $stable(position) && $stable(overflowed))
		else $error("stalled response changed");

	// a query occupies the probe chain
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_take |=> req_stall)
		else $error("request taken while a query is in flight");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		query_take && !rsp_valid |=> !rsp_valid)
		else $error("response appeared right after a query");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> position == '0)
		else $error("nonzero index on a miss");

endmodule

bind sorted_table_bound_search stbs_port_checks u_stbs_port_checks (.*);

// ===== tb/sv/stbs_checker.sv =====
// stbs_checker: watches both channels of sorted_table_bound_search, keeps a shadow
// table, predicts every query response and compares it field by field
// depends on stbs_pkg
module stbs_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  logic             op,
	input  logic             restart,
	input  stbs_pkg::mode_t  mode,
	input  stbs_pkg::value_t value,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  logic             found,
	input  stbs_pkg::pos_t   position,
	input  logic             overflowed,
	output int               mismatches,
	output int               outstanding
);
	import stbs_pkg::*;

	value_t shadow [DEPTH];
	int     shadow_count = 0;
	logic   shadow_ovf   = 1'b0;
	res_t   due_responses [$];
	int     n_bad = 0;
	int     n_due = 0;

	assign mismatches  = n_bad;
	assign outstanding = n_due;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		n_bad++;
	endtask

	// number of leading entries that sort ahead of the target, same probe order as the block
	function automatic int entries_ahead(input value_t target, input logic inclusive);
		int   lo;
		int   hi;
		int   mid;
		logic ahead;
		lo = 0;
		hi = shadow_count;
		while (lo < hi) begin
			mid   = (lo + hi) >> 1;
			ahead = inclusive ? (shadow[mid] <= target) : (shadow[mid] < target);
			if (ahead) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	function automatic res_t predict_bound(input mode_t md, input value_t target);
		res_t r;
		int   b;
		logic inclusive;
		logic want_last;
		inclusive    = (md == MODE_LAST_AT_OR_BELOW) || (md == MODE_FIRST_ABOVE);
		want_last    = (md == MODE_LAST_BELOW) || (md == MODE_LAST_AT_OR_BELOW);
		b            = entries_ahead(target, inclusive);
		r.found      = 1'b0;
		r.position   = '0;
		r.overflowed = shadow_ovf;
		if (want_last && b > 0) begin
			r.found    = 1'b1;
			r.position = pos_t'(b - 1);
		end else if (!want_last && b < shadow_count) begin
			r.found    = 1'b1;
			r.position = pos_t'(b);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			shadow_count = 0;
			shadow_ovf   = 1'b0;
			due_responses.delete();
			n_due <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_responses.size() == 0) begin
					report_mismatch("response with no query pending, found", found, 0);
				end else begin
					want = due_responses.pop_front();
					if (found !== want.found)
						report_mismatch("found", found, want.found);
					if (position !== want.position)
						report_mismatch("position", position, want.position);
					if (overflowed !== want.overflowed)
						report_mismatch("overflowed", overflowed, want.overflowed);
				end
			end
			if (req_valid && !req_stall) begin
				if (op == OP_QUERY) begin
					due_responses.push_back(predict_bound(mode, value));
				end else begin
					if (restart) begin
						shadow_count = 0;
						shadow_ovf   = 1'b0;
					end
					// a full table drops the append and latches overflow
					if (shadow_count >= DEPTH) begin
						shadow_ovf = 1'b1;
					end else begin
						shadow[shadow_count] = value;
						shadow_count++;
					end
				end
			end
			n_due <= due_responses.size();
		end
	end

endmodule

// ===== tb/sv/tb_sorted_table_bound_search.sv =====
// tb_sorted_table_bound_search: request stimulus, response back-pressure and verdict
// depends on stbs_pkg, sorted_table_bound_search and stbs_checker
module tb_sorted_table_bound_search;
	import stbs_pkg::*;

	localparam int     CYCLE_LIMIT  = 1000000;
	localparam int     RANDOM_ITEMS = 1800;
	localparam value_t VAL_MIN      = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam value_t VAL_MAX      = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   req_valid  = 1'b0;
	logic   req_stall;
	logic   op         = OP_APPEND;
	logic   restart    = 1'b0;
	mode_t  mode       = MODE_LAST_BELOW;
	value_t value      = '0;
	logic   rsp_valid;
	logic   rsp_stall  = 1'b0;
	logic   found;
	pos_t   position;
	logic   overflowed;
	int     mismatches;
	int     outstanding;

	int     cycles     = 0;
	int     stall_left = 0;
	int     n_sent     = 0;
	logic   no_gaps    = 1'b0;
	value_t loaded [$];

	always #6 clk = ~clk;

	sorted_table_bound_search dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.restart    (restart),
		.mode       (mode),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found      (found),
		.position   (position),
		.overflowed (overflowed)
	);

	stbs_checker bound_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.restart     (restart),
		.mode        (mode),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.found       (found),
		.position    (position),
		.overflowed  (overflowed),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// response back-pressure: mostly short bursts, now and then a long hold or a clear run
	always @(posedge clk) begin
		int r;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				rsp_stall  <= 1'b0;
				stall_left <= $urandom_range(0, 8);
			end else if (r < 85) begin
				rsp_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else if (r < 95) begin
				rsp_stall  <= 1'b0;
				stall_left <= $urandom_range(20, 80);
			end else begin
				rsp_stall  <= 1'b1;
				stall_left <= $urandom_range(20, 60);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(input logic o, input logic rs, input mode_t md, input value_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= o;
		restart   <= rs;
		mode      <= md;
		value     <= v;
		do @(posedge clk); while (req_stall);
		n_sent++;
	endtask

	// mode is a don't-care on append, restart on query; both get random bits
	task automatic append(input logic rs, input value_t v);
		send_request(OP_APPEND, rs, mode_t'($urandom_range(0, 3)), v);
	endtask

	task automatic query(input mode_t md, input value_t v);
		send_request(OP_QUERY, $urandom_range(0, 1) == 1, md, v);
	endtask

	// narrow tables repeat values so equal runs get searched
	task automatic load_table(input int n, input logic ascending, input logic narrow);
		value_t v;
		int     base;
		loaded.delete();
		base = $urandom;
		for (int i = 0; i < n; i++) begin
			v = narrow ? value_t'(base + $urandom_range(0, 15)) : value_t'($urandom);
			loaded.push_back(v);
		end
		if (ascending)
			loaded.sort();
		foreach (loaded[i])
			append(i == 0, loaded[i]);
	endtask

	function automatic value_t pick_target();
		int     r;
		value_t v;
		r = $urandom_range(0, 9);
		if (loaded.size() == 0 || r < 2)
			return value_t'($urandom);
		if (r == 2)
			return VAL_MIN;
		if (r == 3)
			return VAL_MAX;
		v = loaded[$urandom_range(0, loaded.size() - 1)];
		if (r < 7)
			return v;
		if (r == 7)
			return v - 1;
		return v + 1;
	endfunction

	initial begin
		value_t targets [3];
		logic   filled;
		int     kind;
		filled = 1'b0;
		targets[0] = VAL_MIN;
		targets[1] = '0;
		targets[2] = VAL_MAX;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, every mode
		query(MODE_LAST_BELOW, VAL_MAX);
		query(MODE_FIRST_AT_OR_ABOVE, VAL_MIN);
		query(MODE_LAST_AT_OR_BELOW, VAL_MAX);
		query(MODE_FIRST_ABOVE, VAL_MIN);

		// extremes and a duplicate pair
		append(1'b1, VAL_MIN);
		append(1'b0, -1);
		append(1'b0, 0);
		append(1'b0, 0);
		append(1'b0, VAL_MAX);
		foreach (targets[t]) begin
			query(MODE_LAST_BELOW, targets[t]);
			query(MODE_FIRST_AT_OR_ABOVE, targets[t]);
			query(MODE_LAST_AT_OR_BELOW, targets[t]);
			query(MODE_FIRST_ABOVE, targets[t]);
		end

		while (n_sent < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			kind    = $urandom_range(0, 9);
			if (!filled && n_sent >= 600) begin
				// fill to capacity, overflow, then search the full table
				load_table(DEPTH, 1'b1, 1'b0);
				repeat (4) append(1'b0, value_t'($urandom));
				query(MODE_LAST_BELOW, VAL_MAX);
				query(MODE_FIRST_AT_OR_ABOVE, VAL_MAX);
				repeat (20) query(mode_t'($urandom_range(0, 3)), pick_target());
				filled = 1'b1;
			end else if (kind < 7) begin
				load_table($urandom_range(0, 3) == 0 ? $urandom_range(1, 48) : $urandom_range(1, 12),
					$urandom_range(0, 6) != 0, $urandom_range(0, 2) == 0);
				repeat ($urandom_range(2, 12)) query(mode_t'($urandom_range(0, 3)), pick_target());
			end else begin
				repeat ($urandom_range(3, 10)) begin
					if ($urandom_range(0, 1) == 1)
						query(mode_t'($urandom_range(0, 3)), pick_target());
					else
						append($urandom_range(0, 3) == 0, value_t'($urandom));
				end
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/stbs_pkg.sv
hdl/stbs_table.sv
hdl/stbs_cell.sv
hdl/sorted_table_bound_search.sv
hdl/stbs_checker.sv
tb/sv/stbs_checker.sv
tb/sv/tb_sorted_table_bound_search.sv
